// File: hw/rtl/fhs_pkg.sv
// ----------------------------------------------------------------------------
// fhs_pkg
// Types and codes shared by the semaphore front end, execution unit and
// result queue.
// ----------------------------------------------------------------------------
package fhs_pkg;

    // Command field encoding
    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;

    // Result status encoding
    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd1;
    localparam logic [2:0] ST_QUEUED      = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd3;
    localparam logic [2:0] ST_INCREMENTED = 3'd4;
    localparam logic [2:0] ST_HANDED_OFF  = 3'd5;
    localparam logic [2:0] ST_CANCELLED   = 3'd6;
    localparam logic [2:0] ST_NOT_WAITING = 3'd7;

    // Classified operations passed from front end to execution unit
    localparam logic [2:0] OP_ACQ_TRY  = 3'd0;
    localparam logic [2:0] OP_ACQ_WAIT = 3'd1;
    localparam logic [2:0] OP_RELEASE  = 3'd2;
    localparam logic [2:0] OP_CANCEL   = 3'd3;
    localparam logic [2:0] OP_NOP      = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] requester_id;
        logic       blocking;
    } t_item;

    typedef struct packed {
        logic [2:0]        status;
        logic              grant_valid;
        logic [3:0]        grant_id;
        logic signed [15:0] count_now;
        logic [4:0]        waiting_now;
    } t_result;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] requester_id;
    } t_op;

endpackage

// File: hw/rtl/fhs_front.sv
// ----------------------------------------------------------------------------
// fhs_front
// Accepts input items, classifies them into operations and holds them in a
// two-entry queue for the execution unit.
// ----------------------------------------------------------------------------
module fhs_front
    import fhs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_item i_item,
    output logic  o_op_valid,
    output t_op   o_op,
    input  logic  i_op_take
);

    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_acc;
    t_op        w_op;

    assign full       = (r_cnt == 2'd2);
    assign w_acc      = push && !full;
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rp];

    always_comb begin
        w_op.requester_id = i_item.requester_id;
        unique case (i_item.cmd)
            CMD_ACQUIRE: w_op.op = i_item.blocking ? OP_ACQ_WAIT : OP_ACQ_TRY;
            CMD_RELEASE: w_op.op = OP_RELEASE;
            CMD_CANCEL:  w_op.op = OP_CANCEL;
            default:     w_op.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= ~r_wp;
            end
            if (i_op_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, i_op_take};
        end
    end

endmodule

// File: hw/rtl/fhs_back.sv
// ----------------------------------------------------------------------------
// fhs_back
// Executes semaphore operations: count, circular waiter memory, hand-off and
// cancel with a scan and compaction pass over the waiter memory.
// ----------------------------------------------------------------------------
module fhs_back
    import fhs_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_op_valid,
    input  t_op                     i_op,
    output logic                    o_op_take,
    input  logic                    i_res_room,
    output logic                    o_res_push,
    output t_result                 o_res,
    input  logic                    i_cfg_valid,
    input  logic signed [15:0]      i_cfg_data
);

    localparam int LW = $clog2(MAX_WAITERS + 1);
    localparam int PW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int SW = LW + 1;
    localparam int WW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int XW = (LW > 5) ? LW : 5;
    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = ~CMAX;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HAND  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [3:0]                    r_mem [MAX_WAITERS];
    logic [3:0]                    r_rd_data;
    logic [1:0]                    r_state, n_state;
    logic signed [COUNT_WIDTH-1:0] r_count, n_count;
    logic [PW-1:0]                 r_head, n_head;
    logic [LW-1:0]                 r_len, n_len;
    logic [LW-1:0]                 r_pos, n_pos;
    logic [3:0]                    r_id, n_id;

    logic          w_we;
    logic [PW-1:0] w_waddr;
    logic [3:0]    w_wdata;
    logic [PW-1:0] w_raddr;
    logic          w_emit;
    logic [2:0]    w_status;
    logic          w_gvalid;
    logic [3:0]    w_gid;
    logic [SW-1:0] w_pos1;
    logic [SW-1:0] w_pos2;
    logic [SW-1:0] w_lenx;
    logic          w_cnt_pos;
    logic          w_qfull;

    logic signed [WW-1:0]          w_cfg_x;
    logic signed [COUNT_WIDTH-1:0] w_cfg_count;
    logic signed [WW-1:0]          w_cnt_x;
    logic [XW-1:0]                 w_len_x;

    // physical slot of queue position pos (head at position 0)
    function automatic logic [PW-1:0] f_addr(input logic [PW-1:0] head,
                                              input logic [LW-1:0] pos);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(pos);
        if (s >= SW'(MAX_WAITERS)) begin
            s = s - SW'(MAX_WAITERS);
        end
        return s[PW-1:0];
    endfunction

    assign w_pos1    = SW'(r_pos) + SW'(1);
    assign w_pos2    = SW'(r_pos) + SW'(2);
    assign w_lenx    = SW'(r_len);
    assign w_cnt_pos = !r_count[COUNT_WIDTH-1] && (r_count != '0);
    assign w_qfull   = (r_len == LW'(MAX_WAITERS));

    // config value clamped to the count range
    always_comb begin
        w_cfg_x = WW'(i_cfg_data);
        if (w_cfg_x > WW'(CMAX)) begin
            w_cfg_count = CMAX;
        end else if (w_cfg_x < WW'(CMIN)) begin
            w_cfg_count = CMIN;
        end else begin
            w_cfg_count = w_cfg_x[COUNT_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_len    = r_len;
        n_pos    = r_pos;
        n_id     = r_id;
        w_we     = 1'b0;
        w_waddr  = r_head;
        w_wdata  = r_rd_data;
        w_raddr  = r_head;
        w_emit   = 1'b0;
        w_status = ST_NOT_WAITING;
        w_gvalid = 1'b0;
        w_gid    = 4'd0;
        o_op_take = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // result queue room is checked at start; only this unit fills it
                if (i_op_valid && i_res_room) begin
                    o_op_take = 1'b1;
                    unique case (i_op.op)
                        OP_ACQ_TRY, OP_ACQ_WAIT: begin
                            w_emit = 1'b1;
                            if (w_cnt_pos && r_len == '0) begin
                                n_count  = r_count - COUNT_WIDTH'(1);
                                w_status = ST_GRANTED;
                                w_gvalid = 1'b1;
                                w_gid    = i_op.requester_id;
                            end else if (i_op.op == OP_ACQ_TRY) begin
                                w_status = ST_WOULD_BLOCK;
                            end else if (w_qfull) begin
                                w_status = ST_QUEUE_FULL;
                            end else begin
                                w_we     = 1'b1;
                                w_waddr  = f_addr(r_head, r_len);
                                w_wdata  = i_op.requester_id;
                                n_len    = r_len + LW'(1);
                                w_status = ST_QUEUED;
                            end
                        end
                        OP_RELEASE: begin
                            if (r_count[COUNT_WIDTH-1] || r_len == '0) begin
                                if (r_count != CMAX) begin
                                    n_count = r_count + COUNT_WIDTH'(1);
                                end
                                w_emit   = 1'b1;
                                w_status = ST_INCREMENTED;
                            end else begin
                                w_raddr = r_head;
                                n_state = S_HAND;
                            end
                        end
                        OP_CANCEL: begin
                            if (r_len == '0) begin
                                w_emit   = 1'b1;
                                w_status = ST_NOT_WAITING;
                            end else begin
                                w_raddr = r_head;
                                n_pos   = '0;
                                n_id    = i_op.requester_id;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            w_emit   = 1'b1;
                            w_status = ST_NOT_WAITING;
                        end
                    endcase
                end
            end
            S_HAND: begin
                w_emit   = 1'b1;
                w_status = ST_HANDED_OFF;
                w_gvalid = 1'b1;
                w_gid    = r_rd_data;
                n_head   = (r_head == PW'(MAX_WAITERS - 1)) ? '0 : r_head + PW'(1);
                n_len    = r_len - LW'(1);
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                // r_rd_data holds the entry at r_pos
                if (r_rd_data == r_id) begin
                    if (w_pos1 < w_lenx) begin
                        w_raddr = f_addr(r_head, w_pos1[LW-1:0]);
                        n_state = S_SHIFT;
                    end else begin
                        n_len    = r_len - LW'(1);
                        w_emit   = 1'b1;
                        w_status = ST_CANCELLED;
                        n_state  = S_IDLE;
                    end
                end else if (w_pos1 < w_lenx) begin
                    n_pos   = w_pos1[LW-1:0];
                    w_raddr = f_addr(r_head, w_pos1[LW-1:0]);
                end else begin
                    w_emit   = 1'b1;
                    w_status = ST_NOT_WAITING;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT: begin
                // move entry r_pos+1 down to r_pos, prefetch r_pos+2
                w_we    = 1'b1;
                w_waddr = f_addr(r_head, r_pos);
                w_wdata = r_rd_data;
                n_pos   = w_pos1[LW-1:0];
                if (w_pos2 < w_lenx) begin
                    w_raddr = f_addr(r_head, w_pos2[LW-1:0]);
                end else begin
                    n_len    = r_len - LW'(1);
                    w_emit   = 1'b1;
                    w_status = ST_CANCELLED;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cnt_x = WW'(n_count);
    assign w_len_x = XW'(n_len);

    assign o_res_push          = w_emit;
    assign o_res.status        = w_status;
    assign o_res.grant_valid   = w_gvalid;
    assign o_res.grant_id      = w_gid;
    assign o_res.count_now     = w_cnt_x[15:0];
    assign o_res.waiting_now   = w_len_x[4:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
        r_pos     <= n_pos;
        r_id      <= n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= COUNT_WIDTH'(1);
            r_head  <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_len   <= n_len;
            if (i_cfg_valid) begin
                r_count <= w_cfg_count;
            end else begin
                r_count <= n_count;
            end
        end
    end

endmodule

// File: hw/rtl/fhs_res_q.sv
// ----------------------------------------------------------------------------
// fhs_res_q
// Two-entry result queue between the execution unit and the result port.
// ----------------------------------------------------------------------------
module fhs_res_q
    import fhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_result    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign empty    = (r_cnt == 2'd0);
    assign o_room   = (r_cnt != 2'd2);
    assign w_pop    = pop && !empty;
    assign o_result = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: hw/rtl/fifo_handoff_semaphore_unit.sv
// Path: an item is registered in the front-end queue, executed by the execution
//   unit and its result registered in the result queue; a hand-off release adds
//   a waiter memory read, and a cancel adds a scan of the queued positions and
//   a move of each entry behind the match. The execution unit takes one item per
//   pass and no new item until that pass ends, nor while the result queue is full.
// Reset (synchronous, active low): count = 1, waiter queue empty, all queues
//   empty. A configuration write reloads the count and keeps the waiters.
// ----------------------------------------------------------------------------
// fifo_handoff_semaphore_unit
// Counting semaphore with FIFO waiters and direct hand-off: front end,
// execution unit and result queue.
// ----------------------------------------------------------------------------
module fifo_handoff_semaphore_unit
    import fhs_pkg::*;
#(
    parameter int MAX_WAITERS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_item              i_item,
    output logic               empty,
    input  logic               pop,
    output t_result            o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [15:0] i_cfg_data
);

    logic    w_op_valid;
    t_op     w_op;
    logic    w_op_take;
    logic    w_res_room;
    logic    w_res_push;
    t_result w_res;

    // count reload has no wait states
    assign o_cfg_ready = 1'b1;

    fhs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_op_valid (w_op_valid),
        .o_op       (w_op),
        .i_op_take  (w_op_take)
    );

    fhs_back #(
        .MAX_WAITERS (MAX_WAITERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .i_op        (w_op),
        .o_op_take   (w_op_take),
        .i_res_room  (w_res_room),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );

    fhs_res_q u_res_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_res    (w_res),
        .o_room   (w_res_room),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule
